/* sv/dsa_pkg.sv */
package dsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int FUNC_W     = 2;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 64;
  localparam int CAP_W      = 11;
  localparam int STRIDE_W   = 12;
  localparam int PROD_W     = SLOT_W + STRIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd2;

  localparam logic [CAP_W-1:0]    CAPACITY_RST = 11'd1024;
  localparam logic [ADDR_W-1:0]   BASE_RST     = 64'd0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST   = 12'd32;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot_index;
    logic              no_slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_index;
    logic [ADDR_W-1:0]   slot_address;
  } out_item_t;

  typedef struct packed {
    logic [CAP_W-1:0]    capacity;
    logic [ADDR_W-1:0]   base_address;
    logic [STRIDE_W-1:0] slot_stride;
  } cfg_regs_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] push_idx;
  } stk_ctrl_t;

endpackage

/* sv/dsa_cfg_regs.sv */
module dsa_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output dsa_pkg::cfg_regs_t               cfg_out
);
  import dsa_pkg::*;

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign cfg_out   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.capacity     <= CAPACITY_RST;
      regs_r.base_address <= BASE_RST;
      regs_r.slot_stride  <= STRIDE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAPACITY: regs_r.capacity     <= cfg_wdata[CAP_W-1:0];
        CFG_BASE:     regs_r.base_address <= cfg_wdata[ADDR_W-1:0];
        CFG_STRIDE:   regs_r.slot_stride  <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/dsa_free_stack.sv */
module dsa_free_stack #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF,
  parameter int CNT_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsa_pkg::stk_ctrl_t          ctrl,
  output logic [CNT_W-1:0]            count,
  output logic [dsa_pkg::SLOT_W-1:0]  top
);
  import dsa_pkg::*;

  localparam int PTR_W = $clog2(MAX_SLOTS);

  logic [SLOT_W-1:0] mem [MAX_SLOTS];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [SLOT_W-1:0] top_r;
  logic [PTR_W-1:0]  wr_addr;
  logic [PTR_W-1:0]  rd_addr;

  always_comb begin
    priority if (ctrl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  assign wr_addr = PTR_W'(count_r);
  // prefetch the entry that becomes top after this cycle's update
  assign rd_addr = PTR_W'(count_nxt - 1'b1);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_addr] <= ctrl.push_idx;
    end
    // forward a fresh push; the array write lands at the same edge
    if (ctrl.push) begin
      top_r <= ctrl.push_idx;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign top   = top_r;

endmodule

/* sv/descriptor_slot_allocator.sv */
// Descriptor slot allocator for a fixed pool of MAX_SLOTS descriptors.
// Input channel (in_valid/in_stall/in_item): one request per item, func is
// allocate, release or address lookup. Result channel (out_valid/out_stall/
// out_item): exactly one result item per request, in request order, with a
// status, the granted slot for allocate and the slot address for lookup.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata): index 0
// capacity, 1 base address, 2 slot stride; write only while idle.
// An accepted item lands in the input register, is resolved against the
// free stack top and counters, and its result is presented from the
// result register. Throughput: one item per cycle while the result is
// not stalled; the free stack keeps its top in a register refilled from
// the stack array, or from a forwarded push, at every update.
// Reset empties the free stack, clears the bump counter and loads capacity
// 1024, base 0 and stride 32; no clearing pass, items accepted at once.
// A stalled result holds in the result register; the input register stays
// full behind it and in_stall rises until the result is taken.
module descriptor_slot_allocator #(
  parameter int MAX_SLOTS = dsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dsa_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dsa_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  cfg_regs_t         cfg;
  stk_ctrl_t         stk_ctrl;
  logic [CNT_W-1:0]  stk_count;
  logic [SLOT_W-1:0] stk_top;

  logic              in_vld_r;
  in_item_t          in_r;
  logic              out_vld_r;
  out_item_t         out_r;
  logic [CNT_W-1:0]  bump_count_r;

  logic              advance;
  logic              fire;
  logic              at_cap;
  logic              idx_ge_bump;
  logic              stk_full;
  logic [PROD_W-1:0] prod;
  logic              push_req;
  logic              pop_req;
  logic              bump_req;
  out_item_t         res;

  dsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_out   (cfg)
  );

  dsa_free_stack #(
    .MAX_SLOTS (MAX_SLOTS),
    .CNT_W     (CNT_W)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (stk_ctrl),
    .count (stk_count),
    .top   (stk_top)
  );

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  assign at_cap      = (CMP_W'(bump_count_r) >= CMP_W'(cfg.capacity)) ||
                       (bump_count_r == CNT_W'(MAX_SLOTS));
  assign idx_ge_bump = CMP_W'(in_r.slot_index) >= CMP_W'(bump_count_r);
  assign stk_full    = stk_count == CNT_W'(MAX_SLOTS);
  assign prod        = PROD_W'(in_r.slot_index) * PROD_W'(cfg.slot_stride);

  always_comb begin
    res      = '0;
    push_req = 1'b0;
    pop_req  = 1'b0;
    bump_req = 1'b0;
    res.status = ST_OK;
    unique case (in_r.func)
      FUNC_ALLOC: begin
        priority if (stk_count != '0) begin
          pop_req           = 1'b1;
          res.granted_index = stk_top;
        end else if (at_cap) begin
          res.status = ST_OOM;
        end else begin
          bump_req          = 1'b1;
          res.granted_index = SLOT_W'(bump_count_r);
        end
      end
      FUNC_RELEASE: begin
        if (!in_r.no_slot) begin
          if (idx_ge_bump || stk_full) begin
            res.status = ST_BAD;
          end else begin
            push_req = 1'b1;
          end
        end
      end
      FUNC_LOOKUP: begin
        if (idx_ge_bump) begin
          res.status = ST_BAD;
        end else begin
          res.slot_address = cfg.base_address + ADDR_W'(prod);
        end
      end
      default: ;
    endcase
  end

  assign stk_ctrl.push     = fire && push_req;
  assign stk_ctrl.pop      = fire && pop_req;
  assign stk_ctrl.push_idx = in_r.slot_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      bump_count_r <= '0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      if (fire && bump_req) begin
        bump_count_r <= bump_count_r + 1'b1;
      end
    end
  end

  // payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_item;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_count <= CNT_W'(MAX_SLOTS)) && (bump_count_r <= CNT_W'(MAX_SLOTS)))
    else $error("free or bump count beyond pool size");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_r.func == FUNC_ALLOC && stk_count != '0)
    |=> (stk_count == $past(stk_count) - 1'b1) && $stable(bump_count_r))
    else $error("allocate from free stack did not pop exactly one entry");

  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.push |=> (stk_top == $past(in_r.slot_index)) &&
                      (stk_count == $past(stk_count) + 1'b1))
    else $error("released slot not at top of free stack");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed item produced no result");

endmodule
